// ===== src/sidf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidf_pkg
// Shared types and constants for the sync/id/length frame deframer.
// ----------------------------------------------------------------------------
package sidf_pkg;

  // Field widths fixed by the interface
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned IDX_W    = 6;

  // Defaults
  localparam int unsigned BUFFER_BYTES_DEF = 64;
  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hA5;

  // Controller states
  typedef enum logic [2:0] {
    ST_HUNT,    // waiting for sync byte
    ST_ID,      // next byte is the frame id
    ST_LEN,     // next byte is the payload length
    ST_DATA,    // collecting payload bytes
    ST_READ,    // read one stored byte
    ST_SHOW,    // present one replayed byte
    ST_EMPTY    // present the empty-frame item
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load_id;
    logic load_len;
    logic store_byte;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic show_empty;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic sync_match;
    logic len_zero;
    logic buf_full;
    logic frame_done;
    logic replay_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/sync_id_length_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_id_length_frame_deframer_unit
// Hunts for a sync byte, reads id and length, buffers the payload and
// replays it as one item per payload byte (one empty item for length 0).
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ----------------------------
//  in        input      in_valid_i/in_stall_o  rx_byte_i
//  out       output     out_valid_o/out_stall_i frame_id_o, frame_length_o,
//                                               data_byte_o, payload_pos_o,
//                                               last_o, empty_frame_o
//  cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (sync pattern)
//
//  Received bytes are taken while the block is parsing.
//  Replay reads each stored byte from the buffer, then presents it as an
//  item held while out_stall_i is high, and only then reads another byte; the input
//  is stalled during replay. An empty frame gives one item the next cycle.
//  Reset returns to sync hunt and loads sync pattern 0xA5; no clearing pass.
//
module sync_id_length_frame_deframer_unit
  import sidf_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [BYTE_W-1:0] cfg_data_i,
  // received bytes
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  // replayed items
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [BYTE_W-1:0]      frame_id_o,
  output logic [LEN_W-1:0]       frame_length_o,
  output logic [BYTE_W-1:0]      data_byte_o,
  output logic [IDX_W-1:0]       payload_pos_o,
  output logic                   last_o,
  output logic                   empty_frame_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  sidf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Registers and payload buffer
  sidf_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .frame_id_o     (frame_id_o),
    .frame_length_o (frame_length_o),
    .data_byte_o    (data_byte_o),
    .payload_pos_o  (payload_pos_o),
    .last_o         (last_o),
    .empty_frame_o  (empty_frame_o)
  );

endmodule
`default_nettype wire

// ===== src/sidf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidf_ctrl
// Frame parsing and replay sequencer; drives the datapath by commands.
// ----------------------------------------------------------------------------
module sidf_ctrl
  import sidf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   in_acc;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // Input side open only while parsing
  assign in_stall_o = !((state_q == ST_HUNT) || (state_q == ST_ID) ||
                        (state_q == ST_LEN) || (state_q == ST_DATA));
  assign in_acc     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_HUNT: begin
        if (in_acc && status_i.sync_match) state_d = ST_ID;
      end
      ST_ID: begin
        if (in_acc) begin
          cmd_o.load_id = 1'b1;
          state_d       = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_acc) begin
          cmd_o.load_len = 1'b1;
          state_d        = status_i.len_zero ? ST_EMPTY : ST_DATA;
        end
      end
      ST_DATA: begin
        if (in_acc) begin
          if (status_i.buf_full) begin
            // overflow: drop this byte and the frame
            state_d = ST_HUNT;
          end else begin
            cmd_o.store_byte = 1'b1;
            if (status_i.frame_done) begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (status_i.replay_last) begin
            state_d = ST_HUNT;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      ST_EMPTY: begin
        out_valid_o      = 1'b1;
        cmd_o.show_empty = 1'b1;
        if (!out_stall_i) state_d = ST_HUNT;
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/sidf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidf_datapath
// Sync register, frame header registers, payload buffer and replay index.
// ----------------------------------------------------------------------------
module sidf_datapath
  import sidf_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [BYTE_W-1:0] cfg_data_i,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_status_t             status_o,
  output logic [BYTE_W-1:0]      frame_id_o,
  output logic [LEN_W-1:0]       frame_length_o,
  output logic [BYTE_W-1:0]      data_byte_o,
  output logic [IDX_W-1:0]       payload_pos_o,
  output logic                   last_o,
  output logic                   empty_frame_o
);

  localparam int unsigned AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_BYTES);

  logic [BYTE_W-1:0] sync_q;
  logic [BYTE_W-1:0] id_q;
  logic [BYTE_W-1:0] len_q;
  logic [CW-1:0]     cnt_q;
  logic [AW-1:0]     idx_q;
  logic [BYTE_W-1:0] rd_q;
  logic [BYTE_W-1:0] mem_q [BUFFER_BYTES];
  logic [CW-1:0]     cnt_inc;
  logic [CW-1:0]     idx_inc;

  // Sync pattern register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
    end else if (cfg_valid_i) begin
      sync_q <= cfg_data_i;
    end
  end

  // Header and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q  <= '0;
      len_q <= '0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.load_id) id_q <= rx_byte_i;
      if (cmd_i.load_len) begin
        len_q <= rx_byte_i;
        cnt_q <= '0;
      end else if (cmd_i.store_byte) begin
        cnt_q <= cnt_inc;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  // Payload buffer, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) mem_q[cnt_q[AW-1:0]] <= rx_byte_i;
    if (cmd_i.rd_en) rd_q <= mem_q[idx_q];
  end

  assign cnt_inc = cnt_q + CW'(1);
  assign idx_inc = CW'(idx_q) + CW'(1);

  // Status to the controller
  assign status_o.sync_match  = (rx_byte_i == sync_q);
  assign status_o.len_zero    = (rx_byte_i == '0);
  assign status_o.buf_full    = (cnt_q >= FULL_CNT);
  assign status_o.frame_done  = (BYTE_W'(cnt_inc) == len_q);
  assign status_o.replay_last = (idx_inc == cnt_q);

  // Result fields
  assign frame_id_o     = id_q;
  assign frame_length_o = cmd_i.show_empty ? '0 : len_q[LEN_W-1:0];
  assign data_byte_o    = cmd_i.show_empty ? '0 : rd_q;
  assign payload_pos_o  = cmd_i.show_empty ? '0 : IDX_W'(idx_q);
  assign last_o         = cmd_i.show_empty | status_o.replay_last;
  assign empty_frame_o  = cmd_i.show_empty;

endmodule
`default_nettype wire
